/* rtl/kdeu_pkg.sv */
package kdeu_pkg;

    // keypad line codes: one zero bit marks the active line
    localparam logic [3:0] LINE_CODE_3   = 4'd7;
    localparam logic [3:0] LINE_CODE_2   = 4'd11;
    localparam logic [3:0] LINE_CODE_1   = 4'd13;
    localparam logic [3:0] LINE_CODE_0   = 4'd14;
    localparam logic [3:0] NIB_RELEASED  = 4'hf;
    localparam logic [3:0] NUM_DIGIT_KEYS = 4'd10;

    // entry cell control, broadcast along the chain; the units cell drops clear when shift is set
    typedef struct packed {
        logic shift;
        logic clear;
    } t_cell_ctl;

    // display cell control
    typedef struct packed {
        logic load;
        logic shift;
    } t_disp_ctl;

    function automatic logic [1:0] line_index(input logic [3:0] nib);
        logic [1:0] idx;
        case (nib)
            LINE_CODE_3: idx = 2'd3;
            LINE_CODE_2: idx = 2'd2;
            LINE_CODE_1: idx = 2'd1;
            LINE_CODE_0: idx = 2'd0;
            default:     idx = 2'd0;
        endcase
        return idx;
    endfunction

endpackage

/* rtl/kdeu_key_ctrl.sv */
module kdeu_key_ctrl #(
    parameter int DISPLAY_DIGITS = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  logic                 i_pressed,
    input  logic [3:0]           i_high_nibble,
    input  logic [3:0]           i_low_nibble,
    output kdeu_pkg::t_cell_ctl  o_ctl,
    output logic [3:0]           o_digit
);
    localparam int CW = $clog2(DISPLAY_DIGITS + 1);

    logic [3:0]    r_prev_key, n_prev_key;
    logic [CW-1:0] r_count, n_count;
    logic [3:0]    w_key;
    logic          w_full;

    // released low nibble reuses the previous key
    assign w_key  = (i_low_nibble != kdeu_pkg::NIB_RELEASED) ?
                    {kdeu_pkg::line_index(i_low_nibble), kdeu_pkg::line_index(i_high_nibble)} :
                    r_prev_key;
    assign w_full = (r_count >= CW'(DISPLAY_DIGITS));
    assign o_digit = w_key;

    always_comb begin
        n_prev_key  = r_prev_key;
        n_count     = r_count;
        o_ctl.shift = 1'b0;
        o_ctl.clear = 1'b0;
        if (i_accept && i_pressed) begin
            n_prev_key = w_key;
            if (w_key < kdeu_pkg::NUM_DIGIT_KEYS) begin
                if (w_full) begin
                    // restart with this single digit
                    o_ctl.shift = 1'b1;
                    o_ctl.clear = 1'b1;
                    n_count     = CW'(1);
                end else if (w_key != 4'd0 || r_count != '0) begin
                    o_ctl.shift = 1'b1;
                    n_count     = r_count + CW'(1);
                end
            end else begin
                o_ctl.clear = 1'b1;
                n_count     = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_key <= '0;
            r_count    <= '0;
        end else begin
            r_prev_key <= n_prev_key;
            r_count    <= n_count;
        end
    end

endmodule

/* rtl/kdeu_entry_cell.sv */
module kdeu_entry_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  kdeu_pkg::t_cell_ctl i_ctl,
    input  logic [3:0]          i_prev,
    input  logic                i_nz_above,
    output logic [3:0]          o_digit,
    output logic                o_nz
);
    logic [3:0] r_digit, n_digit;

    always_comb begin
        n_digit = r_digit;
        if (i_ctl.clear) begin
            n_digit = 4'd0;
        end else if (i_ctl.shift) begin
            n_digit = i_prev;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_digit <= 4'd0;
        end else begin
            r_digit <= n_digit;
        end
    end

    assign o_digit = r_digit;
    // nonzero here or anywhere above
    assign o_nz    = (r_digit != 4'd0) | i_nz_above;

endmodule

/* rtl/kdeu_disp_cell.sv */
module kdeu_disp_cell (
    input  logic                i_clk,
    input  kdeu_pkg::t_disp_ctl i_ctl,
    input  logic [3:0]          i_load_digit,
    input  logic                i_load_blank,
    input  logic [3:0]          i_up_digit,
    input  logic                i_up_blank,
    output logic [3:0]          o_digit,
    output logic                o_blank
);
    logic [3:0] r_digit;
    logic       r_blank;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_digit <= i_load_blank ? 4'd0 : i_load_digit;
            r_blank <= i_load_blank;
        end else if (i_ctl.shift) begin
            r_digit <= i_up_digit;
            r_blank <= i_up_blank;
        end
    end

    assign o_digit = r_digit;
    assign o_blank = r_blank;

endmodule

/* rtl/keypad_decimal_entry_display_unit.sv */
// An accepted scan updates the entry cells and is then loaded into the display cells; digits
// leave one per cycle while the output is ready, units first. A new scan is taken once the
// previous refresh has been loaded, so it overlaps the running refresh.
// Reset (i_rst_n, synchronous, active low) clears the entered digits, count, previous
// key and handshake control; no clearing pass is needed.
module keypad_decimal_entry_display_unit #(
    parameter int DISPLAY_DIGITS = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // slave side: one keypad scan per transaction
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,   // [3:0] high_nibble, [7:4] low_nibble
    input  logic       i_s_axis_tuser,   // [0] key_pressed
    // master side: one display digit per transaction
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,   // [2:0] digit_position, [6:3] digit_value, [7] zero
    output logic       o_m_axis_tuser,   // [0] blank
    output logic       o_m_axis_tlast    // last digit of the refresh
);
    localparam int D  = DISPLAY_DIGITS;
    localparam int PW = (D > 1) ? $clog2(D) : 1;

    // control: r_pend = entry updated, refresh not yet loaded into display chain
    logic          r_pend, n_pend;
    logic          r_busy, n_busy;
    logic [PW-1:0] r_pos, n_pos;

    logic w_in_acc, w_out_acc, w_final_acc, w_reload;

    kdeu_pkg::t_cell_ctl w_key_ctl;
    kdeu_pkg::t_cell_ctl w_cell_ctl [D];
    kdeu_pkg::t_disp_ctl w_disp_ctl;
    logic [3:0]          w_new_digit;

    logic [3:0] w_entry   [D];
    logic [3:0] w_prev    [D];
    logic       w_nz      [D];
    logic       w_nz_up   [D];
    logic [3:0] w_d_digit [D];
    logic       w_d_blank [D];
    logic [3:0] w_up_dig  [D];
    logic       w_up_blk  [D];

    // a new scan is taken once the previous one has been copied into the display chain,
    // so the next scan overlaps the running refresh
    assign o_s_axis_tready = !r_pend;
    assign w_in_acc        = i_s_axis_tvalid && !r_pend;
    assign w_out_acc       = r_busy && i_m_axis_tready;
    assign w_final_acc     = w_out_acc && (r_pos == '0);
    assign w_reload        = r_pend && (!r_busy || w_final_acc);

    kdeu_key_ctrl #(
        .DISPLAY_DIGITS(D)
    ) u_key_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (w_in_acc),
        .i_pressed    (i_s_axis_tuser),
        .i_high_nibble(i_s_axis_tdata[3:0]),
        .i_low_nibble (i_s_axis_tdata[7:4]),
        .o_ctl        (w_key_ctl),
        .o_digit      (w_new_digit)
    );

    // entry chain: cell 0 holds units, digits shift upward on a new digit key
    for (genvar k = 0; k < D; k++) begin : g_entry
        if (k == 0) begin : g_units
            // restart keeps the new digit in the units cell
            assign w_cell_ctl[k].shift = w_key_ctl.shift;
            assign w_cell_ctl[k].clear = w_key_ctl.clear & ~w_key_ctl.shift;
            assign w_prev[k]           = w_new_digit;
        end else begin : g_upper
            assign w_cell_ctl[k] = w_key_ctl;
            assign w_prev[k]     = w_entry[k-1];
        end
        if (k == D - 1) begin : g_top
            assign w_nz_up[k] = 1'b0;
        end else begin : g_mid
            assign w_nz_up[k] = w_nz[k+1];
        end

        kdeu_entry_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctl     (w_cell_ctl[k]),
            .i_prev    (w_prev[k]),
            .i_nz_above(w_nz_up[k]),
            .o_digit   (w_entry[k]),
            .o_nz      (w_nz[k])
        );
    end

    // display chain: snapshot on reload, then shift down towards cell 0 (units out first)
    assign w_disp_ctl.load  = w_reload;
    assign w_disp_ctl.shift = w_out_acc && !w_reload;

    for (genvar k = 0; k < D; k++) begin : g_disp
        if (k == D - 1) begin : g_top
            assign w_up_dig[k] = 4'd0;
            assign w_up_blk[k] = 1'b0;
        end else begin : g_mid
            assign w_up_dig[k] = w_d_digit[k+1];
            assign w_up_blk[k] = w_d_blank[k+1];
        end

        kdeu_disp_cell u_disp (
            .i_clk       (i_clk),
            .i_ctl       (w_disp_ctl),
            .i_load_digit(w_entry[k]),
            // units never blanked; others blank when this and all above are zero
            .i_load_blank((k != 0) && !w_nz[k]),
            .i_up_digit  (w_up_dig[k]),
            .i_up_blank  (w_up_blk[k]),
            .o_digit     (w_d_digit[k]),
            .o_blank     (w_d_blank[k])
        );
    end

    // position counts down from units (D-1) to the highest digit (0)
    always_comb begin
        n_pend = r_pend;
        n_busy = r_busy;
        n_pos  = r_pos;
        if (w_in_acc) begin
            n_pend = 1'b1;
        end else if (w_reload) begin
            n_pend = 1'b0;
        end
        if (w_reload) begin
            n_busy = 1'b1;
            n_pos  = PW'(D - 1);
        end else if (w_out_acc) begin
            if (r_pos == '0) begin
                n_busy = 1'b0;
            end else begin
                n_pos = r_pos - PW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
            r_busy <= 1'b0;
            r_pos  <= '0;
        end else begin
            r_pend <= n_pend;
            r_busy <= n_busy;
            r_pos  <= n_pos;
        end
    end

    assign o_m_axis_tvalid = r_busy;
    assign o_m_axis_tdata  = {1'b0, w_d_digit[0], 3'(r_pos)};
    assign o_m_axis_tuser  = w_d_blank[0];
    assign o_m_axis_tlast  = (r_pos == '0);

`ifndef SYNTHESIS
    // units digit is never blanked
    a_units_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && r_pos == PW'(D - 1)) |-> !o_m_axis_tuser)
        else $error("units digit blanked");

    // blanked digit carries value zero
    a_blank_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser) |-> (o_m_axis_tdata[6:3] == 4'd0))
        else $error("blanked digit with nonzero value");

    // refresh ends after its final digit when nothing is pending
    a_refresh_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && i_m_axis_tready && o_m_axis_tlast && !r_pend)
        |=> !o_m_axis_tvalid)
        else $error("output valid after final digit");

    // an accepted scan blocks the input until its refresh is loaded
    a_one_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("second scan taken before refresh load");
`endif

endmodule

/* bench/kdeu_refresh_checker.sv */
module kdeu_refresh_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    input  logic       i_s_tready,
    input  logic [7:0] i_s_tdata,   // [3:0] high_nibble, [7:4] low_nibble
    input  logic       i_s_tuser,   // [0] key_pressed
    input  logic       i_m_tvalid,
    input  logic       i_m_tready,
    input  logic [7:0] i_m_tdata,   // [2:0] digit_position, [6:3] digit_value, [7] zero
    input  logic       i_m_tuser,   // [0] blank
    input  logic       i_m_tlast,
    output int         o_fail_count,
    output int         o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DIGITS = 8;

    typedef struct packed {
        logic [2:0] position;
        logic [3:0] value;
        logic       blank;
        logic       is_last;
    } t_shown_digit;

    t_shown_digit shown_q[$];
    logic [3:0]   entered [DIGITS];   // index 0 = units
    logic [3:0]   entered_count;
    logic [3:0]   held_key;
    int           mismatches = 0;

    function automatic logic [1:0] line_of(input logic [3:0] nib);
        if (nib == kdeu_pkg::LINE_CODE_3) return 2'd3;
        if (nib == kdeu_pkg::LINE_CODE_2) return 2'd2;
        if (nib == kdeu_pkg::LINE_CODE_1) return 2'd1;
        return 2'd0;   // line 0 and every malformed nibble
    endfunction

    task automatic clear_entry();
        for (int k = 0; k < DIGITS; k++) entered[k] = '0;
        entered_count = '0;
    endtask

    // update the entry for one scan, then queue its full refresh
    task automatic apply_scan(input logic pressed, input logic [3:0] hi, input logic [3:0] lo);
        logic         nz_from [DIGITS];
        logic         above;
        t_shown_digit d;
        if (pressed) begin
            if (lo != kdeu_pkg::NIB_RELEASED) held_key = {line_of(lo), line_of(hi)};
            if (held_key >= kdeu_pkg::NUM_DIGIT_KEYS) begin
                clear_entry();
            end else if (entered_count == DIGITS) begin
                clear_entry();
                entered[0]    = held_key;
                entered_count = 4'd1;
            end else if (held_key != 4'd0 || entered_count != 4'd0) begin
                for (int k = DIGITS - 1; k > 0; k--) entered[k] = entered[k - 1];
                entered[0]    = held_key;
                entered_count = entered_count + 4'd1;
            end
        end
        above = 1'b0;
        for (int k = DIGITS - 1; k >= 0; k--) begin
            if (entered[k] != 4'd0) above = 1'b1;
            nz_from[k] = above;
        end
        for (int k = 0; k < DIGITS; k++) begin
            d.position = 3'(DIGITS - 1 - k);
            d.blank    = (k != 0) && !nz_from[k];
            d.value    = d.blank ? 4'd0 : entered[k];
            d.is_last  = (k == DIGITS - 1);
            shown_q.push_back(d);
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_shown_digit want;
        t_shown_digit got;
        string        want_s;
        string        got_s;
        if (!i_rst_n) begin
            clear_entry();
            held_key = '0;
            shown_q.delete();
        end else begin
            if (i_s_tvalid && i_s_tready)
                apply_scan(i_s_tuser, i_s_tdata[3:0], i_s_tdata[7:4]);
            if (i_m_tvalid && i_m_tready) begin
                got = {i_m_tdata[2:0], i_m_tdata[6:3], i_m_tuser, i_m_tlast};
                if (shown_q.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected digit, got position %0d value %0d blank %b last %b",
                             $realtime, got.position, got.value, got.blank, got.is_last);
                end else begin
                    want = shown_q.pop_front();
                    if (got !== want || i_m_tdata[7] !== 1'b0) begin
                        mismatches++;
                        want_s = $sformatf("position %0d value %0d blank %b last %b pad 0",
                                           want.position, want.value, want.blank,
                                           want.is_last);
                        got_s  = $sformatf("position %0d value %0d blank %b last %b pad %b",
                                           got.position, got.value, got.blank,
                                           got.is_last, i_m_tdata[7]);
                        $display("%0t: digit mismatch, expected %s, got %s",
                                 $realtime, want_s, got_s);
                    end
                end
            end
        end
        o_fail_count <= mismatches;
        o_pending    <= shown_q.size();
    end

endmodule

/* bench/tb_keypad_decimal_entry_display_unit.sv */
module tb_keypad_decimal_entry_display_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int RANDOM_SCANS = 400;
    localparam int HOLD_SCAN    = 150;   // scan index at which the long output hold is asked
    localparam int HOLD_CYCLES  = 400;
    localparam int TAIL_CYCLES  = 20;    // ample drain time after the last expected digit

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = '0;    // [3:0] high_nibble, [7:4] low_nibble
    logic       s_tuser = 1'b0;  // [0] key_pressed
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;         // [2:0] digit_position, [6:3] digit_value, [7] zero
    logic       m_tuser;         // [0] blank
    logic       m_tlast;

    int         fail_count;
    int         pending;
    int         cycle_count = 0;

    // coordination between sender and receiver
    bit         tx_steady = 1'b0;       // sender offers back to back
    bit         hold_req = 1'b0;        // sender asks the receiver for the long hold
    bit         rx_hold_active = 1'b0;

    keypad_decimal_entry_display_unit u_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .o_m_axis_tlast  (m_tlast)
    );

    kdeu_refresh_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tuser    (m_tuser),
        .i_m_tlast    (m_tlast),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin : clock_gen
        forever #5 clk = ~clk;
    end

    // one-cold nibble for a matrix line index: 0 -> 14, 1 -> 13, 2 -> 11, 3 -> 7
    function automatic logic [3:0] line_nibble(input logic [1:0] idx);
        return 4'hf ^ (4'd1 << idx);
    endfunction

    // Idle gap ahead of the next scan: mostly none, some short, a few long.
    // Back-to-back phases and the long output hold force zero gaps so the
    // block fills up behind the stalled receiver.
    function automatic int pick_gap();
        int r;
        if (tx_steady || rx_hold_active) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Offer one scan and wait for its transaction. If no gap follows the
    // previous transaction, valid simply stays high and only the data moves.
    task automatic send_scan(input logic pressed, input logic [3:0] hi, input logic [3:0] lo);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= pressed;
        s_tdata  <= {lo, hi};
        do @(posedge clk); while (!s_tready);
    endtask

    // key code = high line index + 4 * low line index
    task automatic press_key(input logic [3:0] key);
        send_scan(1'b1, line_nibble(key[1:0]), line_nibble(key[3:2]));
    endtask

    // Receiver: random runs of ready and stall, plus one long hold on request.
    initial begin : receiver
        int r;
        int run;
        bit hold_done;
        hold_done = 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever begin
            if (hold_req && !hold_done) begin
                hold_done      = 1'b1;
                rx_hold_active = 1'b1;
                m_tready      <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                rx_hold_active = 1'b0;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 45) begin
                    m_tready <= 1'b1;
                    run = $urandom_range(1, 20);
                end else if (r < 55) begin
                    m_tready <= 1'b1;              // stretch with no stalls
                    run = $urandom_range(50, 150);
                end else if (r < 90) begin
                    m_tready <= 1'b0;
                    run = $urandom_range(1, 3);
                end else begin
                    m_tready <= 1'b0;
                    run = $urandom_range(10, 60);
                end
                repeat (run) @(posedge clk);
            end
        end
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb_keypad_decimal_entry_display_unit failed");
        $finish;
    end

    initial begin : stimulus
        int r;
        logic [3:0] key;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // ---- directed part ----
        send_scan(1'b0, 4'h0, 4'h0);            // refresh straight after reset: a lone 0
        press_key(4'd0);                        // leading zero, ignored
        for (int k = 1; k <= 8; k++)            // fills all eight digits: 12345678
            press_key(4'(k));
        press_key(4'd0);                        // entry full: restarts as a single 0
        press_key(4'd9);
        send_scan(1'b1, 4'h0, kdeu_pkg::NIB_RELEASED);  // released low nibble repeats the 9
        press_key(4'd10);                       // non-digit key clears
        press_key(4'd5);
        press_key(4'd0);                        // zero after a digit is kept: 50
        press_key(4'd11);
        for (int k = 12; k <= 15; k++)          // remaining non-digit keys
            press_key(4'(k));
        send_scan(1'b1, 4'h0, 4'h0);            // every line marked: decodes to key 0
        send_scan(1'b1, 4'hf, 4'h3);            // malformed nibbles: key 0 again
        send_scan(1'b0, 4'hf, 4'hf);            // refresh only

        // ---- random part ----
        // Mostly clean key presses, biased towards digits so the entry often
        // runs full; the rest is refreshes, releases and malformed nibbles.
        for (int n = 0; n < RANDOM_SCANS; n++) begin
            tx_steady = ((n / 50) % 2) == 1;
            if (n == HOLD_SCAN) hold_req = 1'b1;
            r = $urandom_range(0, 99);
            if (r < 10) begin
                send_scan(1'b0, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
            end else if (r < 15) begin
                send_scan(1'b1, 4'($urandom_range(0, 15)), kdeu_pkg::NIB_RELEASED);
            end else if (r < 25) begin
                send_scan(1'b1, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
            end else begin
                if ($urandom_range(0, 99) < 85)
                    key = 4'($urandom_range(0, kdeu_pkg::NUM_DIGIT_KEYS - 1));
                else
                    key = 4'($urandom_range(kdeu_pkg::NUM_DIGIT_KEYS, 15));
                press_key(key);
            end
        end
        s_tvalid <= 1'b0;

        // drain: the checker's pending count is registered and lags the queue
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (fail_count == 0 && pending == 0)
            $display("tb_keypad_decimal_entry_display_unit passed");
        else
            $display("tb_keypad_decimal_entry_display_unit failed");
        $finish;
    end

endmodule

/* keypad_decimal_entry_display_unit.f */
rtl/kdeu_pkg.sv
rtl/kdeu_key_ctrl.sv
rtl/kdeu_entry_cell.sv
rtl/kdeu_disp_cell.sv
rtl/keypad_decimal_entry_display_unit.sv
bench/kdeu_refresh_checker.sv
bench/tb_keypad_decimal_entry_display_unit.sv
